### rtl/lfuc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfuc_pkg
// Shared constants and controller/datapath interface types for the LFU cache.
// ----------------------------------------------------------------------------
package lfuc_pkg;

	localparam int ENTRIES   = 16;
	localparam int CNT_W     = 16;
	localparam int KEY_W     = 32;
	localparam int VAL_W     = 32;
	localparam int CAP_W     = 5;
	localparam int CAP_RESET = 16;
	localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int OCC_W     = $clog2(ENTRIES + 1);

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	// controller -> datapath commands
	typedef struct packed {
		logic load;
		logic match;
		logic touch;
		logic scan_clr;
		logic scan_step;
		logic evict;
		logic insert;
		logic finish;
	} lfuc_cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic hit;
		logic op_put;
		logic cap_zero;
		logic full;
		logic scan_last;
		logic out_busy;
	} lfuc_sts_t;

endpackage

### rtl/lfuc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfuc_ctrl
// Sequencer: steps one operation through match, update, victim scan, evict, insert and result.
// ----------------------------------------------------------------------------
module lfuc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  lfuc_pkg::lfuc_sts_t sts,
	output lfuc_pkg::lfuc_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_MATCH  = 3'd1;
	localparam logic [2:0] ST_ROUTE  = 3'd2;
	localparam logic [2:0] ST_TOUCH  = 3'd3;
	localparam logic [2:0] ST_SCAN   = 3'd4;
	localparam logic [2:0] ST_EVICT  = 3'd5;
	localparam logic [2:0] ST_INSERT = 3'd6;
	localparam logic [2:0] ST_FINISH = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_MATCH;
				end
			end
			ST_MATCH: begin
				cmd.match = 1'b1;
				state_d   = ST_ROUTE;
			end
			ST_ROUTE: begin
				if (sts.hit && !(sts.op_put && sts.cap_zero)) begin
					state_d = ST_TOUCH;
				end else if (!sts.op_put || sts.cap_zero) begin
					state_d = ST_FINISH;
				end else if (sts.full) begin
					cmd.scan_clr = 1'b1;
					state_d      = ST_SCAN;
				end else begin
					state_d = ST_INSERT;
				end
			end
			ST_TOUCH: begin
				cmd.touch = 1'b1;
				state_d   = ST_FINISH;
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_EVICT;
				end
			end
			ST_EVICT: begin
				cmd.evict = 1'b1;
				state_d   = ST_INSERT;
			end
			ST_INSERT: begin
				cmd.insert = 1'b1;
				state_d    = ST_FINISH;
			end
			ST_FINISH: begin
				// hold until the output register is free
				if (!sts.out_busy) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### rtl/lfuc_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfuc_dpath
// Entry storage, key match, recency/count update, victim scan and result reg.
// ----------------------------------------------------------------------------
module lfuc_dpath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lfuc_pkg::CAP_W-1:0]     cfg_data,
	input  logic                           in_op,
	input  logic [lfuc_pkg::KEY_W-1:0]     in_key,
	input  logic [lfuc_pkg::VAL_W-1:0]     in_val,
	input  lfuc_pkg::lfuc_cmd_t            cmd,
	output lfuc_pkg::lfuc_sts_t            sts,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           out_hit,
	output logic [lfuc_pkg::VAL_W-1:0]     out_val
);

	localparam int E = lfuc_pkg::ENTRIES;

	logic [lfuc_pkg::CAP_W-1:0] capacity_q;
	logic                       op_q;
	logic [lfuc_pkg::KEY_W-1:0] key_q;
	logic [lfuc_pkg::VAL_W-1:0] wval_q;

	logic [E-1:0]               valid_q;
	logic [lfuc_pkg::KEY_W-1:0] ekey_q  [E];
	logic [lfuc_pkg::VAL_W-1:0] eval_q  [E];
	logic [lfuc_pkg::CNT_W-1:0] cnt_q   [E];
	logic [lfuc_pkg::IDX_W-1:0] rank_q  [E];
	logic [lfuc_pkg::OCC_W-1:0] occ_q;

	logic [E-1:0]               match_oh_q;
	logic                       hit_q;
	logic [lfuc_pkg::VAL_W-1:0] hit_val_q;
	logic [lfuc_pkg::IDX_W-1:0] hit_rank_q;

	logic [lfuc_pkg::IDX_W-1:0] scan_idx_q;
	logic                       found_q;
	logic [lfuc_pkg::IDX_W-1:0] best_idx_q;
	logic [lfuc_pkg::CNT_W-1:0] best_cnt_q;
	logic [lfuc_pkg::IDX_W-1:0] best_rank_q;

	logic                       out_valid_q;
	logic                       out_hit_q;
	logic [lfuc_pkg::VAL_W-1:0] out_val_q;

	// combinational helpers
	logic [E-1:0]               eq;
	logic [lfuc_pkg::VAL_W-1:0] eq_val;
	logic [lfuc_pkg::IDX_W-1:0] eq_rank;
	logic                       any_free;
	logic [lfuc_pkg::IDX_W-1:0] free_idx;
	logic                       scan_take;
	logic                       full;

	always_comb begin
		eq_val  = '0;
		eq_rank = '0;
		for (int i = 0; i < E; i++) begin
			eq[i] = valid_q[i] && (ekey_q[i] == key_q);
			if (eq[i]) begin
				eq_val  = eq_val | eval_q[i];
				eq_rank = eq_rank | rank_q[i];
			end
		end
	end

	// lowest-numbered free entry
	always_comb begin
		any_free = 1'b0;
		free_idx = '0;
		for (int i = E - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				any_free = 1'b1;
				free_idx = lfuc_pkg::IDX_W'(i);
			end
		end
	end

	// lower count wins; on equal count the older entry (higher rank) wins
	assign scan_take = valid_q[scan_idx_q] &&
		(!found_q || (cnt_q[scan_idx_q] < best_cnt_q) ||
		 ((cnt_q[scan_idx_q] == best_cnt_q) && (rank_q[scan_idx_q] > best_rank_q)));

	assign full = (32'(occ_q) >= 32'(capacity_q)) || (32'(occ_q) >= 32'(E));

	assign sts.hit       = hit_q;
	assign sts.op_put    = (op_q == lfuc_pkg::OP_PUT);
	assign sts.cap_zero  = (capacity_q == '0);
	assign sts.full      = full;
	assign sts.scan_last = (32'(scan_idx_q) == 32'(E - 1));
	assign sts.out_busy  = out_valid_q && !out_ready;

	assign out_valid = out_valid_q;
	assign out_hit   = out_hit_q;
	assign out_val   = out_val_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= lfuc_pkg::CAP_W'(lfuc_pkg::CAP_RESET);
			valid_q     <= '0;
			occ_q       <= '0;
			found_q     <= 1'b0;
			scan_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				capacity_q <= cfg_data;
			end
			if (cmd.scan_clr) begin
				scan_idx_q <= '0;
				found_q    <= 1'b0;
			end else if (cmd.scan_step) begin
				scan_idx_q <= scan_idx_q + 1'b1;
				if (scan_take) begin
					found_q <= 1'b1;
				end
			end
			if (cmd.evict && found_q) begin
				valid_q[best_idx_q] <= 1'b0;
				if (occ_q != '0) begin
					occ_q <= occ_q - 1'b1;
				end
			end
			if (cmd.insert && any_free) begin
				valid_q[free_idx] <= 1'b1;
				occ_q             <= occ_q + 1'b1;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= in_op;
			key_q  <= in_key;
			wval_q <= in_val;
		end
		if (cmd.match) begin
			match_oh_q <= eq;
			hit_q      <= |eq;
			hit_val_q  <= eq_val;
			hit_rank_q <= eq_rank;
		end
		if (cmd.scan_step && scan_take) begin
			best_idx_q  <= scan_idx_q;
			best_cnt_q  <= cnt_q[scan_idx_q];
			best_rank_q <= rank_q[scan_idx_q];
		end
		for (int i = 0; i < E; i++) begin
			if (cmd.touch) begin
				if (match_oh_q[i]) begin
					rank_q[i] <= '0;
					if (cnt_q[i] != '1) begin
						cnt_q[i] <= cnt_q[i] + 1'b1;
					end
					if (op_q == lfuc_pkg::OP_PUT) begin
						eval_q[i] <= wval_q;
					end
				end else if (valid_q[i] && (rank_q[i] < hit_rank_q)) begin
					rank_q[i] <= rank_q[i] + 1'b1;
				end
			end
			if (cmd.evict && found_q && valid_q[i] && (rank_q[i] > best_rank_q)) begin
				rank_q[i] <= rank_q[i] - 1'b1;
			end
			if (cmd.insert && any_free) begin
				if (32'(free_idx) == 32'(i)) begin
					ekey_q[i] <= key_q;
					eval_q[i] <= wval_q;
					cnt_q[i]  <= lfuc_pkg::CNT_W'(1);
					rank_q[i] <= '0;
				end else if (valid_q[i]) begin
					rank_q[i] <= rank_q[i] + 1'b1;
				end
			end
		end
		if (cmd.finish) begin
			out_hit_q <= hit_q;
			out_val_q <= (hit_q && (op_q == lfuc_pkg::OP_GET)) ? hit_val_q : '1;
		end
	end

`ifndef SYNTHESIS
	a_occ_tracks_valid: assert property (@(posedge clk) disable iff (!arst_n)
		32'(occ_q) == 32'($countones(valid_q)))
		else $error("occupancy does not match valid entries");

	a_key_unique: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.match |=> $onehot0(match_oh_q))
		else $error("key present in more than one entry");

	a_touch_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.touch |-> hit_q && $onehot(match_oh_q))
		else $error("update issued without a matching entry");

	a_evict_has_victim: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.evict |-> found_q)
		else $error("eviction with no victim found");

	a_insert_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert |-> any_free)
		else $error("insert with no free entry");
`endif

endmodule

### rtl/lfu_cache_with_lru_tiebreak.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_cache_with_lru_tiebreak
// Key-value cache, least-frequently-used replacement, oldest entry on ties.
// ----------------------------------------------------------------------------
// channel | dir | tdata              | tuser
// s_*     | in  | key, write_value   | operation (0 get, 1 put)
// m_*     | out | read_value         | hit
// cfg     | in  | capacity (5 bits)  | -
//
// Get miss, or any put while capacity is zero: match, route, result;
// get hit or put hit: match, route, update, result.
// Put of a new key: match, route, insert, result; when the cache is full,
// a victim scan visiting one entry per cycle and an evict precede the insert.
// A new input is taken while a result waits in the output register; a
// stalled output holds the next result back at its final step.
// Reset clears all entries and sets capacity to 16; no clearing pass.
// ----------------------------------------------------------------------------
module lfu_cache_with_lru_tiebreak (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] key, [63:32] write_value
	input  logic        s_tuser,   // [0] operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] read_value
	output logic        m_tuser    // [0] hit
);

	lfuc_pkg::lfuc_cmd_t cmd;
	lfuc_pkg::lfuc_sts_t sts;

	lfuc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lfuc_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.in_op     (s_tuser),
		.in_key    (s_tdata[31:0]),
		.in_val    (s_tdata[63:32]),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_hit   (m_tuser),
		.out_val   (m_tdata)
	);

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LFU cache with LRU tie-break. A directed table
// covers field extremes, capacity zero, capacity above the entry count and a
// capacity lowered below occupancy. Random get/put traffic over a small key
// pool then runs under several capacity settings, and a run of gets raises
// one use count well above the rest before fresh keys crowd it. Each result
// is compared against a transaction-level model of the cache kept inside the
// bench, or against the expected reply that a pinned directed row gives.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int   ENTRIES   = lfuc_pkg::ENTRIES;
	localparam int   CNT_W     = lfuc_pkg::CNT_W;
	localparam int   CAP_RESET = lfuc_pkg::CAP_RESET;
	localparam logic OP_GET    = lfuc_pkg::OP_GET;
	localparam logic OP_PUT    = lfuc_pkg::OP_PUT;

	localparam logic [31:0] MISS_VALUE  = 32'hffff_ffff;
	localparam int          POOL_SIZE   = 24;
	localparam int          PHASES      = 11;
	localparam int          PHASE_ITEMS = 66;
	localparam int          LONG_HOLD   = 300;
	localparam int          SETTLE      = ENTRIES + 10;
	localparam int          SAT_GETS    = 20;

	localparam int CAP_PLAN [PHASES] = '{16, 31, 1, 2, 0, 5, 16, 17, 3, 8, 15};

	typedef enum logic {ROW_ACCESS, ROW_CAPACITY} row_kind_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] read_value;
	} cache_reply_t;

	typedef struct packed {
		row_kind_t   kind;
		logic        op;
		logic [31:0] key;
		logic [31:0] wval;
		logic [4:0]  cap;
		logic        pinned;
		logic        exp_hit;
		logic [31:0] exp_val;
	} stim_row_t;

	localparam int DIRECTED_ROWS = 30;
	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{ROW_ACCESS, OP_GET, 32'h0000_0000, 32'h0000_0000, 5'd0, 1'b1, 1'b0, MISS_VALUE},
		'{ROW_ACCESS, OP_PUT, 32'h7fff_ffff, 32'h8000_0000, 5'd0, 1'b1, 1'b0, MISS_VALUE},
		'{ROW_ACCESS, OP_GET, 32'h7fff_ffff, 32'h0000_0000, 5'd0, 1'b1, 1'b1, 32'h8000_0000},
		'{ROW_ACCESS, OP_PUT, 32'h8000_0000, 32'h7fff_ffff, 5'd0, 1'b1, 1'b0, MISS_VALUE},
		'{ROW_ACCESS, OP_GET, 32'h8000_0000, 32'hffff_ffff, 5'd0, 1'b1, 1'b1, 32'h7fff_ffff},
		'{ROW_ACCESS, OP_PUT, 32'h7fff_ffff, 32'hffff_ffff, 5'd0, 1'b1, 1'b1, MISS_VALUE},
		'{ROW_ACCESS, OP_GET, 32'hffff_ffff, 32'h0000_0000, 5'd0, 1'b1, 1'b0, MISS_VALUE},
		'{ROW_ACCESS, OP_PUT, 32'hffff_ffff, 32'h0000_0000, 5'd0, 1'b1, 1'b0, MISS_VALUE},
		'{ROW_ACCESS, OP_GET, 32'hffff_ffff, 32'h0000_0000, 5'd0, 1'b1, 1'b1, 32'h0000_0000},
		// capacity zero: puts are dropped but still report presence
		'{ROW_CAPACITY, OP_GET, 32'h0, 32'h0, 5'd0, 1'b0, 1'b0, 32'h0},
		'{ROW_ACCESS, OP_PUT, 32'h0000_0000, 32'h0000_0005, 5'd0, 1'b1, 1'b0, MISS_VALUE},
		'{ROW_ACCESS, OP_GET, 32'h0000_0000, 32'h0000_0000, 5'd0, 1'b1, 1'b0, MISS_VALUE},
		'{ROW_ACCESS, OP_PUT, 32'hffff_ffff, 32'h0000_0009, 5'd0, 1'b1, 1'b1, MISS_VALUE},
		'{ROW_ACCESS, OP_GET, 32'hffff_ffff, 32'h0000_0000, 5'd0, 1'b1, 1'b1, 32'h0000_0000},
		// capacity below occupancy: a new key evicts one and keeps the level
		'{ROW_CAPACITY, OP_GET, 32'h0, 32'h0, 5'd2, 1'b0, 1'b0, 32'h0},
		'{ROW_ACCESS, OP_PUT, 32'h0000_0001, 32'h0000_0001, 5'd0, 1'b1, 1'b0, MISS_VALUE},
		'{ROW_ACCESS, OP_GET, 32'h8000_0000, 32'h0000_0000, 5'd0, 1'b0, 1'b0, 32'h0},
		'{ROW_ACCESS, OP_PUT, 32'h0000_0002, 32'h0000_0002, 5'd0, 1'b1, 1'b0, MISS_VALUE},
		'{ROW_ACCESS, OP_GET, 32'h0000_0001, 32'h0000_0000, 5'd0, 1'b0, 1'b0, 32'h0},
		// capacity above the entry count
		'{ROW_CAPACITY, OP_GET, 32'h0, 32'h0, 5'd31, 1'b0, 1'b0, 32'h0},
		'{ROW_ACCESS, OP_PUT, 32'h0000_0003, 32'h0000_0003, 5'd0, 1'b1, 1'b0, MISS_VALUE},
		'{ROW_ACCESS, OP_PUT, 32'h0000_0004, 32'h0000_0004, 5'd0, 1'b0, 1'b0, 32'h0},
		'{ROW_ACCESS, OP_GET, 32'h0000_0002, 32'h0000_0000, 5'd0, 1'b0, 1'b0, 32'h0},
		'{ROW_CAPACITY, OP_GET, 32'h0, 32'h0, 5'd1, 1'b0, 1'b0, 32'h0},
		'{ROW_ACCESS, OP_PUT, 32'h0000_0005, 32'h0000_0005, 5'd0, 1'b0, 1'b0, 32'h0},
		'{ROW_ACCESS, OP_GET, 32'h0000_0004, 32'h0000_0000, 5'd0, 1'b0, 1'b0, 32'h0},
		'{ROW_ACCESS, OP_GET, 32'h0000_0005, 32'h0000_0000, 5'd0, 1'b0, 1'b0, 32'h0},
		'{ROW_CAPACITY, OP_GET, 32'h0, 32'h0, 5'd16, 1'b0, 1'b0, 32'h0},
		'{ROW_ACCESS, OP_PUT, 32'h0000_0000, 32'h55aa_55aa, 5'd0, 1'b0, 1'b0, 32'h0},
		'{ROW_ACCESS, OP_GET, 32'h0000_0000, 32'h0000_0000, 5'd0, 1'b0, 1'b0, 32'h0}
	};

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        cfg_we   = 1'b0;
	logic [4:0]  cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata  = '0;   // [31:0] key, [63:32] write_value
	logic        s_tuser  = 1'b0; // [0] operation
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;         // [31:0] read_value
	logic        m_tuser;         // [0] hit

	// cache shadow state
	logic             ent_valid [ENTRIES];
	logic [31:0]      ent_key   [ENTRIES];
	logic [31:0]      ent_val   [ENTRIES];
	logic [CNT_W-1:0] ent_uses  [ENTRIES];
	int unsigned      ent_age   [ENTRIES];
	int unsigned      fill_level;
	logic [4:0]       cap_reg;

	cache_reply_t pending_replies [$];
	int           fail_count = 0;
	int           hold_order = 0;
	int           hold_seen  = 0;
	int           rx_wait    = 0;
	logic         rx_idle_on = 1'b1;
	logic         tx_idle_on = 1'b1;
	logic [31:0]  key_pool [POOL_SIZE];

	lfu_cache_with_lru_tiebreak dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 70) return 0;
		if (roll < 95) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int find_entry(logic [31:0] key);
		for (int i = 0; i < ENTRIES; i++)
			if (ent_valid[i] && ent_key[i] == key) return i;
		return -1;
	endfunction

	// Move entry to most recent and bump its count, holding at the maximum.
	function automatic void promote(int e);
		int unsigned r;
		r = ent_age[e];
		for (int i = 0; i < ENTRIES; i++)
			if (ent_valid[i] && i != e && ent_age[i] < r) ent_age[i]++;
		ent_age[e] = 0;
		if (ent_uses[e] != '1) ent_uses[e]++;
	endfunction

	// Drop the lowest count; on a tie drop the oldest.
	function automatic void evict_victim();
		int v;
		v = -1;
		for (int i = 0; i < ENTRIES; i++) begin
			if (!ent_valid[i]) continue;
			if (v < 0 || ent_uses[i] < ent_uses[v] ||
			    (ent_uses[i] == ent_uses[v] && ent_age[i] > ent_age[v])) v = i;
		end
		if (v < 0) return;
		for (int i = 0; i < ENTRIES; i++)
			if (ent_valid[i] && ent_age[i] > ent_age[v]) ent_age[i]--;
		ent_valid[v] = 1'b0;
		if (fill_level > 0) fill_level--;
	endfunction

	function automatic void cache_apply(input logic op, input logic [31:0] key,
	                                    input logic [31:0] wval, output cache_reply_t reply);
		int unsigned eff_cap;
		int          e;
		int          slot;
		eff_cap = (cap_reg > ENTRIES) ? ENTRIES : cap_reg;
		e = find_entry(key);
		reply.hit = (e >= 0);
		reply.read_value = MISS_VALUE;
		if (op == OP_GET) begin
			if (e >= 0) begin
				reply.read_value = ent_val[e];
				promote(e);
			end
			return;
		end
		if (eff_cap == 0) return;
		if (e >= 0) begin
			ent_val[e] = wval;
			promote(e);
			return;
		end
		if (fill_level >= eff_cap) evict_victim();
		slot = -1;
		for (int i = 0; i < ENTRIES; i++)
			if (!ent_valid[i] && slot < 0) slot = i;
		if (slot < 0) return;
		for (int i = 0; i < ENTRIES; i++)
			if (ent_valid[i]) ent_age[i]++;
		ent_valid[slot] = 1'b1;
		ent_key[slot]   = key;
		ent_val[slot]   = wval;
		ent_uses[slot]  = 1;
		ent_age[slot]   = 0;
		fill_level++;
	endfunction

	task automatic check_reply(input logic hit_got, input logic [31:0] val_got);
		cache_reply_t want;
		if (pending_replies.size() == 0) begin
			$error("result with nothing pending: hit %0b, read_value %h", hit_got, val_got);
			fail_count++;
		end else begin
			want = pending_replies.pop_front();
			if (want.hit !== hit_got) begin
				$error("hit mismatch: expected %0b, actual %0b", want.hit, hit_got);
				fail_count++;
			end
			if (want.read_value !== val_got) begin
				$error("read_value mismatch: expected %h, actual %h",
				       want.read_value, val_got);
				fail_count++;
			end
		end
	endtask

	// Result side: check each transfer, then pick the next ready level.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) check_reply(m_tuser, m_tdata);
			if (hold_order != hold_seen) begin
				hold_seen = hold_order;
				rx_wait = LONG_HOLD;
			end
			if (rx_wait > 0) begin
				m_tready <= 1'b0;
				rx_wait--;
			end else begin
				m_tready <= 1'b1;
				if (rx_idle_on) rx_wait = pick_gap();
			end
		end
	end

	task automatic hold_input(input int n);
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic offer_access(input logic op, input logic [31:0] key, input logic [31:0] wval,
	                            input logic pinned, input cache_reply_t pinned_reply);
		cache_reply_t reply;
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {wval, key};
		do @(posedge clk); while (!s_tready);
		cache_apply(op, key, wval, reply);
		pending_replies.push_back(pinned ? pinned_reply : reply);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_capacity(input logic [4:0] value);
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we  <= 1'b0;
		cap_reg = value;
	endtask

	initial begin
		stim_row_t    row;
		cache_reply_t fixed_reply;
		int           gap;
		int           span;
		logic         op;
		logic [31:0]  key;
		logic [31:0]  sat_key;

		for (int i = 0; i < ENTRIES; i++) begin
			ent_valid[i] = 1'b0;
			ent_key[i]   = '0;
			ent_val[i]   = '0;
			ent_uses[i]  = '0;
			ent_age[i]   = 0;
		end
		fill_level = 0;
		cap_reg = 5'(CAP_RESET);
		key_pool[0] = 32'h0000_0000;
		key_pool[1] = 32'h7fff_ffff;
		key_pool[2] = 32'h8000_0000;
		key_pool[3] = 32'hffff_ffff;
		for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIRECTED_ROWS; r++) begin
			row = DIRECTED[r];
			if (row.kind == ROW_CAPACITY) begin
				drain();
				set_capacity(row.cap);
			end else begin
				fixed_reply = {row.exp_hit, row.exp_val};
				hold_input(pick_gap());
				offer_access(row.op, row.key, row.wval, row.pinned, fixed_reply);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			set_capacity(5'(CAP_PLAN[ph]));
			tx_idle_on = (ph % 4 != 2);
			rx_idle_on <= (ph % 4 != 2);
			span = $urandom_range(2, POOL_SIZE);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// back up the output while inputs keep coming
				if (ph == 3 && n == 10) hold_order <= hold_order + 1;
				if (ph == 5 && n == 35) drain();
				if (ph == 3 && n >= 10 && n < 40) gap = 0;
				else gap = tx_idle_on ? pick_gap() : 0;
				hold_input(gap);
				op = 1'($urandom_range(0, 1));
				if ($urandom_range(0, 9) == 0) key = $urandom;
				else key = key_pool[$urandom_range(0, span - 1)];
				offer_access(op, key, $urandom, 1'b0, '0);
			end
		end

		// raise one key's count well above the rest, then crowd it with fresh keys
		drain();
		set_capacity(5'(CAP_RESET));
		tx_idle_on = 1'b0;
		rx_idle_on <= 1'b0;
		sat_key = key_pool[POOL_SIZE - 1];
		offer_access(OP_PUT, sat_key, 32'h1234_5678, 1'b0, '0);
		repeat (SAT_GETS) offer_access(OP_GET, sat_key, $urandom, 1'b0, '0);
		tx_idle_on = 1'b1;
		rx_idle_on <= 1'b1;
		repeat (2 * ENTRIES) begin
			hold_input(pick_gap());
			offer_access(OP_PUT, $urandom, $urandom, 1'b0, '0);
		end
		offer_access(OP_GET, sat_key, 32'h0, 1'b0, '0);
		offer_access(OP_PUT, sat_key, 32'hdead_beef, 1'b0, '0);
		offer_access(OP_GET, sat_key, 32'h0, 1'b0, '0);
		drain();

		if (fail_count == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end

	initial begin
		#40ms;
		$display("TEST FAILED");
		$finish;
	end

endmodule
